// ===== rtl/core/iir_filter_coef_crossfade_macros.svh =====
// Assertion macros for the IIR crossfade filter.
`ifndef IIR_FILTER_COEF_CROSSFADE_MACROS_SVH
`define IIR_FILTER_COEF_CROSSFADE_MACROS_SVH
`ifndef SYNTH
`define IFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ifc_pkg.sv =====
package ifc_pkg;
  localparam int unsigned MaxTaps = 16;
  localparam int unsigned SampleBits = 24;
  localparam int unsigned CoefBits = 32;
  localparam int unsigned CoefFrac = 24;
  localparam int unsigned GainOne = 65536;
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_COMMIT = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;
  typedef enum logic [1:0] {
    REG_NUM_B = 2'd0,
    REG_NUM_A = 2'd1,
    REG_FADE_LEN = 2'd2,
    REG_FADE_STEP = 2'd3
  } reg_e;
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_NEW_CLR,
    ST_NEW_MAC,
    ST_NEW_FIN,
    ST_OLD_CLR,
    ST_OLD_MAC,
    ST_OLD_FIN,
    ST_SHIFT,
    ST_MIX_A,
    ST_MIX_B,
    ST_MIX_FIN,
    ST_OUT
  } state_e;
endpackage

// ===== rtl/core/iir_filter_coef_crossfade.sv =====
// With n = taps_b plus the feedback terms (taps_a - 1), a sample runs an n-term pass
// with the new coefficients, a second pass with the old ones while a fade runs and a
// crossfade mix for a mixed word, all through one shared multiply-accumulate unit.
// One item at a time: input is ready only in idle; a commit passes a commit state.
// The output register lets the next item enter while a word waits on the output.
// Reset (asynchronous, active low) restores unit coefficient sets and tap counts of 1
// and clears history, fade state and fade registers; no clearing pass is needed.
`include "iir_filter_coef_crossfade_macros.svh"
module iir_filter_coef_crossfade
  import ifc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // mode[1:0], coef_select[2], coef_index[6:3], coef_value[38:7], sample[62:39]
  input  logic [63:0]           s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_sample[23:0]
  output logic [23:0]           m_axis_tdata,
  // fading[0]
  output logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  localparam int unsigned TapW = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
  localparam int unsigned CntW = $clog2(MaxTaps + 1);

  typedef logic signed [CoefBits-1:0] coef_t;
  typedef logic signed [SampleBits-1:0] smp_t;

  logic [4:0]  num_b_q, num_a_q;
  logic [15:0] fade_len_q;
  logic [16:0] fade_step_q;

  coef_t stg_b_q [MaxTaps];
  coef_t stg_a_q [MaxTaps];
  coef_t act_b_q [MaxTaps];
  coef_t act_a_q [MaxTaps];
  coef_t prv_b_q [MaxTaps];
  coef_t prv_a_q [MaxTaps];
  smp_t  xh_q [MaxTaps];
  smp_t  yh_q [MaxTaps];
  smp_t  pyh_q [MaxTaps];

  logic [15:0] fade_cnt_q;
  logic [16:0] fade_gain_q;
  logic        fade_act_q;

  state_e state_q, state_d;
  logic [CntW:0] k_q, k_d;
  logic [1:0]  wait_q, wait_d;
  smp_t        ynew_q, yold_q;
  logic        ovalid_q;
  smp_t        odata_q;
  logic        ofade_q;

  logic [CntW-1:0] nb, na;
  logic [CntW:0]   nb_x, na_x, tot;
  assign nb = (num_b_q > 5'(MaxTaps)) ? CntW'(MaxTaps) : CntW'(num_b_q);
  assign na = (num_a_q > 5'(MaxTaps)) ? CntW'(MaxTaps) : CntW'(num_a_q);
  assign nb_x = (CntW+1)'(nb);
  assign na_x = (na == '0) ? '0 : (CntW+1)'(na) - 1'b1;
  assign tot = nb_x + na_x;

  logic in_acc;
  logic out_load;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!ovalid_q || m_axis_tready);

  mode_e       in_mode;
  logic [TapW-1:0] in_idx;
  assign in_mode = mode_e'(s_axis_tdata[1:0]);
  assign in_idx = TapW'(s_axis_tdata[6:3]);

  // MAC operand selection.
  logic mac_clr, mac_en, mac_sub, old_sel;
  coef_t mac_coef;
  smp_t  mac_data;
  logic signed [63:0] acc;
  logic [CntW:0] ka;
  logic [TapW-1:0] bi, ai;
  logic in_b;
  logic signed [17:0] g_s;
  logic signed [17:0] og_s;

  assign in_b = k_q < nb_x;
  assign ka = k_q - nb_x + 1'b1;
  assign bi = TapW'(k_q);
  assign ai = TapW'(ka);
  assign g_s = 18'(fade_gain_q);
  assign og_s = 18'(GainOne) - 18'(fade_gain_q);

  always_comb begin
    mac_clr = (state_q == ST_NEW_CLR) || (state_q == ST_OLD_CLR) || (state_q == ST_MIX_A);
    mac_en = 1'b0;
    mac_sub = 1'b0;
    mac_coef = '0;
    mac_data = '0;
    old_sel = (state_q == ST_OLD_MAC);
    case (state_q)
      ST_NEW_MAC, ST_OLD_MAC: begin
        if (k_q < tot) begin
          mac_en = 1'b1;
          if (in_b) begin
            mac_coef = old_sel ? prv_b_q[bi] : act_b_q[bi];
            mac_data = xh_q[bi];
          end else begin
            mac_sub = 1'b1;
            mac_coef = old_sel ? prv_a_q[ai] : act_a_q[ai];
            mac_data = old_sel ? pyh_q[ai] : yh_q[ai];
          end
        end
      end
      ST_MIX_B: begin
        if (k_q == '0) begin
          mac_en = 1'b1;
          mac_coef = CoefBits'(og_s);
          mac_data = yold_q;
        end else if (k_q == (CntW+1)'(1)) begin
          mac_en = 1'b1;
          mac_coef = CoefBits'(g_s);
          mac_data = ynew_q;
        end
      end
      default: ;
    endcase
  end

  ifc_mac u_mac (
    .clk_i  (clk_i),
    .clear_i(mac_clr),
    .en_i   (mac_en),
    .sub_i  (mac_sub),
    .coef_i (mac_coef),
    .data_i (mac_data),
    .acc_o  (acc)
  );

  localparam logic signed [63:0] SatHi = 64'((64'sd1 <<< (SampleBits - 1)) - 1);
  localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;
  logic signed [63:0] rnd_f, rnd_m;
  smp_t sat_f, sat_m;
  assign rnd_f = (acc + (64'sd1 <<< (CoefFrac - 1))) >>> CoefFrac;
  assign rnd_m = (acc + 64'sd32768) >>> 16;
  assign sat_f = (rnd_f > SatHi) ? SatHi[SampleBits-1:0] :
                 (rnd_f < SatLo) ? SatLo[SampleBits-1:0] : rnd_f[SampleBits-1:0];
  assign sat_m = (rnd_m > SatHi) ? SatHi[SampleBits-1:0] :
                 (rnd_m < SatLo) ? SatLo[SampleBits-1:0] : rnd_m[SampleBits-1:0];

  logic do_mix;
  assign do_mix = fade_cnt_q < fade_len_q;

  always_comb begin
    state_d = state_q;
    k_d = k_q;
    wait_d = wait_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_SAMPLE: state_d = ST_NEW_CLR;
            MODE_COMMIT: state_d = ST_COMMIT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_COMMIT: state_d = ST_IDLE;
      ST_NEW_CLR: begin
        k_d = '0;
        state_d = ST_NEW_MAC;
      end
      ST_NEW_MAC: begin
        wait_d = 2'd2;
        if (k_q >= tot) state_d = ST_NEW_FIN;
        else k_d = k_q + 1'b1;
      end
      ST_NEW_FIN: begin
        if (wait_q != '0) wait_d = wait_q - 1'b1;
        else state_d = fade_act_q ? ST_OLD_CLR : ST_SHIFT;
      end
      ST_OLD_CLR: begin
        k_d = '0;
        state_d = ST_OLD_MAC;
      end
      ST_OLD_MAC: begin
        wait_d = 2'd2;
        if (k_q >= tot) state_d = ST_OLD_FIN;
        else k_d = k_q + 1'b1;
      end
      ST_OLD_FIN: begin
        if (wait_q != '0) wait_d = wait_q - 1'b1;
        else state_d = ST_SHIFT;
      end
      ST_SHIFT: state_d = (fade_act_q && do_mix) ? ST_MIX_A : ST_OUT;
      ST_MIX_A: begin
        k_d = '0;
        state_d = ST_MIX_B;
      end
      ST_MIX_B: begin
        wait_d = 2'd2;
        if (k_q >= (CntW+1)'(2)) state_d = ST_MIX_FIN;
        else k_d = k_q + 1'b1;
      end
      ST_MIX_FIN: begin
        if (wait_q != '0) wait_d = wait_q - 1'b1;
        else state_d = ST_OUT;
      end
      ST_OUT: state_d = out_load ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q <= '0;
      wait_q <= '0;
    end else begin
      state_q <= state_d;
      k_q <= k_d;
      wait_q <= wait_d;
    end
  end

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_NUM_B: prdata = 32'(num_b_q);
      REG_NUM_A: prdata = 32'(num_a_q);
      REG_FADE_LEN: prdata = 32'(fade_len_q);
      REG_FADE_STEP: prdata = 32'(fade_step_q);
      default: prdata = '0;
    endcase
  end

  logic [17:0] gain_sum;
  assign gain_sum = 18'(fade_gain_q) + 18'(fade_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_b_q <= 5'd1;
      num_a_q <= 5'd1;
      fade_len_q <= '0;
      fade_step_q <= '0;
      fade_cnt_q <= '0;
      fade_gain_q <= '0;
      fade_act_q <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < MaxTaps; i++) begin
        stg_b_q[i] <= (i == 0) ? coef_t'(64'sd1 <<< CoefFrac) : '0;
        stg_a_q[i] <= (i == 0) ? coef_t'(64'sd1 <<< CoefFrac) : '0;
        act_b_q[i] <= (i == 0) ? coef_t'(64'sd1 <<< CoefFrac) : '0;
        act_a_q[i] <= (i == 0) ? coef_t'(64'sd1 <<< CoefFrac) : '0;
        prv_b_q[i] <= (i == 0) ? coef_t'(64'sd1 <<< CoefFrac) : '0;
        prv_a_q[i] <= (i == 0) ? coef_t'(64'sd1 <<< CoefFrac) : '0;
        xh_q[i] <= '0;
        yh_q[i] <= '0;
        pyh_q[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (reg_e'(paddr[3:2]))
          REG_NUM_B: num_b_q <= pwdata[4:0];
          REG_NUM_A: num_a_q <= pwdata[4:0];
          REG_FADE_LEN: fade_len_q <= pwdata[15:0];
          REG_FADE_STEP: fade_step_q <= pwdata[16:0];
          default: ;
        endcase
      end
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (in_acc && in_mode == MODE_WRITE && 5'(s_axis_tdata[6:3]) < 5'(MaxTaps)) begin
        if (s_axis_tdata[2]) stg_a_q[in_idx] <= coef_t'(s_axis_tdata[38:7]);
        else stg_b_q[in_idx] <= coef_t'(s_axis_tdata[38:7]);
      end
      if (in_acc && in_mode == MODE_SAMPLE) xh_q[0] <= smp_t'(s_axis_tdata[62:39]);
      if (state_q == ST_COMMIT) begin
        for (int i = 0; i < MaxTaps; i++) begin
          prv_b_q[i] <= act_b_q[i];
          prv_a_q[i] <= act_a_q[i];
          pyh_q[i] <= yh_q[i];
          act_b_q[i] <= stg_b_q[i];
          act_a_q[i] <= stg_a_q[i];
        end
        fade_cnt_q <= '0;
        fade_gain_q <= '0;
        fade_act_q <= 1'b1;
      end
      if (state_q == ST_SHIFT) begin
        for (int i = 1; i < MaxTaps; i++) begin
          xh_q[i] <= xh_q[i-1];
          yh_q[i] <= (i == 1) ? ynew_q : yh_q[i-1];
          if (fade_act_q) pyh_q[i] <= (i == 1) ? yold_q : pyh_q[i-1];
        end
      end
      if (out_load && fade_act_q) begin
        if (mix_q) begin
          fade_cnt_q <= fade_cnt_q + 1'b1;
          fade_gain_q <= (gain_sum > 18'(GainOne)) ? 17'(GainOne) : gain_sum[16:0];
        end else begin
          fade_act_q <= 1'b0;
        end
      end
    end
  end

  logic mix_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_NEW_FIN && wait_q == '0) ynew_q <= sat_f;
    if (state_q == ST_OLD_FIN && wait_q == '0) yold_q <= sat_f;
    if (state_q == ST_SHIFT) mix_q <= fade_act_q && do_mix;
    if (out_load) begin
      odata_q <= mix_q ? sat_m : ynew_q;
      ofade_q <= mix_q;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = 24'(odata_q);
  assign m_axis_tuser = ofade_q;

  `IFC_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, s_axis_tready, state_q == ST_IDLE)
  `IFC_ASSERT_NEXT(a_commit_fade, clk_i, rst_ni, state_q == ST_COMMIT, fade_act_q)
  `IFC_ASSERT_NEXT(a_out_valid, clk_i, rst_ni, state_q == ST_OUT, m_axis_tvalid)
  `IFC_ASSERT_IMPL(a_gain_cap, clk_i, rst_ni, 1'b1, fade_gain_q <= 17'(GainOne))
endmodule

// ===== rtl/core/ifc_mac.sv =====
module ifc_mac
  import ifc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         clear_i,
  input  logic                         en_i,
  input  logic                         sub_i,
  input  logic signed [CoefBits-1:0]   coef_i,
  input  logic signed [SampleBits-1:0] data_i,
  output logic signed [63:0]           acc_o
);
  localparam int unsigned ProdBits = CoefBits + SampleBits;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [63:0] prod_ext;
  logic signed [63:0] acc_q;
  logic en_q;
  logic sub_q;
  assign prod_ext = 64'(prod_q);
  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * data_i;
    en_q <= en_i;
    sub_q <= sub_i;
    if (clear_i) begin
      acc_q <= '0;
    end else if (en_q) begin
      acc_q <= sub_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
  end
  assign acc_o = acc_q;
endmodule
